// ===== rtl/atk_pkg.sv =====
// ----------------------------------------------------------------------------
// atk_pkg
// Shared types, codes and the clamped add for the Atkinson dither unit.
// ----------------------------------------------------------------------------
package atk_pkg;

  localparam int PIX_W     = 8;
  localparam int SHARE_W   = 5;
  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 1;
  localparam int COORD_W   = 9;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  // request codes
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  localparam int RESET_WIDTH  = 320;
  localparam int RESET_HEIGHT = 240;

  typedef logic [PIX_W-1:0]          pix_t;
  typedef logic signed [SHARE_W-1:0] share_t;

  localparam pix_t PIX_THRESH = 8'd128;
  localparam pix_t PIX_WHITE  = 8'd255;
  localparam pix_t PIX_BLACK  = 8'd0;

  // which earlier decisions reach the pixel being decided
  typedef struct packed {
    logic up_left;
    logic up;
    logic up_right;
    logic left2;
    logic left1;
  } nbr_t;

  typedef struct packed {
    logic               dark;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               last;
  } res_t;

  function automatic pix_t clamp_add(input pix_t v, input share_t s);
    logic [PIX_W+1:0] sum;
    sum = {2'b00, v} + {{(PIX_W+2-SHARE_W){s[SHARE_W-1]}}, s};
    if (sum[PIX_W+1]) begin
      clamp_add = PIX_BLACK;
    end else if (sum[PIX_W]) begin
      clamp_add = PIX_WHITE;
    end else begin
      clamp_add = sum[PIX_W-1:0];
    end
  endfunction

endpackage

// ===== rtl/atk_ram.sv =====
// ----------------------------------------------------------------------------
// atk_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module atk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1025
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/atk_decide.sv =====
// ----------------------------------------------------------------------------
// atk_decide
// Applies the outstanding error shares to a pixel in decision order,
// thresholds it and derives the share it passes on.
// ----------------------------------------------------------------------------
module atk_decide
  import atk_pkg::*;
(
  input  pix_t   base,
  input  share_t sh_up_left,
  input  share_t sh_up,
  input  share_t sh_up_right,
  input  share_t sh_left2,
  input  share_t sh_left1,
  input  nbr_t   nbr,
  output logic   dark,
  output share_t share
);

  pix_t       v1, v2, v3, v4, v5;
  logic [3:0] mag;

  always_comb begin
    v1 = nbr.up_left  ? clamp_add(base, sh_up_left) : base;
    v2 = nbr.up       ? clamp_add(v1, sh_up)        : v1;
    v3 = nbr.up_right ? clamp_add(v2, sh_up_right)  : v2;
    v4 = nbr.left2    ? clamp_add(v3, sh_left2)     : v3;
    v5 = nbr.left1    ? clamp_add(v4, sh_left1)     : v4;
    dark = (v5 < PIX_THRESH);
    // error/8 toward zero: v>>3 when black, -((255-v)>>3) when white
    mag = dark ? v5[6:3] : ~v5[6:3];
    share = dark ? share_t'({1'b0, mag}) : share_t'(5'd0 - {1'b0, mag});
  end

endmodule

// ===== rtl/atkinson_error_diffusion_dither_unit.sv =====
// ----------------------------------------------------------------------------
// atkinson_error_diffusion_dither_unit
// Streaming Atkinson dither of 8-bit gray pixels in raster order.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one request per pixel, req_type 0 with
// the raw gray value, or req_type 1 as a drain step once the frame is loaded.
// Pixel p is decided in the cycle that accepts pixel p+2W; drain steps decide
// the remaining pixels one per request. Pixels beyond the frame and early
// drains are taken and give no result.
// Output channel (out_valid/out_ready): one result per decided pixel, with its
// black/white flag, column, row and a frame-last flag.
// Throughput is one request per cycle while in_ready is high; the decision
// path is combinational, fed by the registered reads of the pixel window RAM and the share RAM.
// A two-entry output stage (register plus skid) keeps in_ready high while one
// result waits; in_ready drops only when both entries are full.
// Configuration writes (cfg_we) set frame width or height and restart the
// frame. Reset (rst_n low, synchronous) restores 320 x 240, empties the frame
// and the output stage. The RAMs need no clearing pass.
// ----------------------------------------------------------------------------
module atkinson_error_diffusion_dither_unit
  import atk_pkg::*;
#(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_req_type,
  input  logic [PIX_W-1:0]     in_pixel_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_pixel_dark,
  output logic [COORD_W-1:0]   out_col,
  output logic [COORD_W-1:0]   out_row,
  output logic                 out_frame_last,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int DA  = 2 * MAX_WIDTH + 1;
  localparam int AAW = $clog2(DA);
  localparam int DS  = MAX_WIDTH;
  localparam int SAW = $clog2(DS);
  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);

  function automatic int unsigned sat_dim(input logic [CFG_W-1:0] v, input int unsigned lim);
    int unsigned d;
    d = int'(v);
    if (d == 0) d = 1;
    if (d > lim) d = lim;
    return d;
  endfunction

  // frame geometry and progress
  logic [WW-1:0]  w_r, w_nxt;
  logic [HW-1:0]  h_r, h_nxt;
  logic [XW-1:0]  lcol_r, lcol_nxt, dcol_r, dcol_nxt;
  logic [YW-1:0]  lrow_r, lrow_nxt, drow_r, drow_nxt;
  logic           full_r, full_nxt;
  logic [AAW-1:0] wa_r, wa_nxt, da_r, da_nxt;
  logic [SAW-1:0] ws_r, ws_nxt;

  // share history
  share_t up0_r, up1_r, sh1_r, sh2_r;

  // ram forwarding
  logic   afwd_r, sfwd_r;
  pix_t   afwd_d_r;
  share_t sfwd_d_r;

  // output stage
  logic ov_r, ov_nxt, skid_v_r, skid_v_nxt;
  logic take_out, take_skid, move_skid;
  res_t out_q_r, skid_q_r, res;

  logic           acc, pix_req, drn_req, load, prime, dec, frame_end, restart;
  logic           l_last_col, l_last_row, d_last_col, d_last_row, out_fire;
  logic [WW-1:0]  w_m1;
  logic [HW-1:0]  h_m1;
  logic [SAW:0]   s_off, s_sum;
  logic [SAW-1:0] s_raddr;
  pix_t           a_rdata, a_wdata, base;
  logic [SHARE_W-1:0] s_rdata;
  share_t         rd_s, share;
  logic           dark;
  nbr_t           nbr;

  assign in_ready = !skid_v_r;

  always_comb begin
    acc     = in_valid && in_ready;
    pix_req = acc && (in_req_type == REQ_PIXEL);
    drn_req = acc && (in_req_type == REQ_DRAIN);
    load    = pix_req && !full_r;
    prime   = 32'(lrow_r) >= 32'd2;
    dec     = (load && prime) || (drn_req && full_r);

    w_m1       = w_r - WW'(1);
    h_m1       = h_r - HW'(1);
    l_last_col = (WW'(lcol_r) == w_m1);
    l_last_row = (HW'(lrow_r) == h_m1);
    d_last_col = (WW'(dcol_r) == w_m1);
    d_last_row = (HW'(drow_r) == h_m1);
    frame_end  = dec && d_last_col && d_last_row;
    restart    = frame_end || cfg_we;

    w_nxt    = w_r;
    h_nxt    = h_r;
    lcol_nxt = lcol_r;
    lrow_nxt = lrow_r;
    full_nxt = full_r;
    dcol_nxt = dcol_r;
    drow_nxt = drow_r;
    wa_nxt   = wa_r;
    da_nxt   = da_r;
    ws_nxt   = ws_r;

    if (load) begin
      wa_nxt = (wa_r == AAW'(DA - 1)) ? '0 : wa_r + AAW'(1);
      if (l_last_col) begin
        lcol_nxt = '0;
        if (l_last_row) begin
          full_nxt = 1'b1;
        end else begin
          lrow_nxt = lrow_r + YW'(1);
        end
      end else begin
        lcol_nxt = lcol_r + XW'(1);
      end
    end

    if (dec) begin
      da_nxt = (da_r == AAW'(DA - 1)) ? '0 : da_r + AAW'(1);
      ws_nxt = (ws_r == SAW'(DS - 1)) ? '0 : ws_r + SAW'(1);
      if (d_last_col) begin
        dcol_nxt = '0;
        drow_nxt = drow_r + YW'(1);
      end else begin
        dcol_nxt = dcol_r + XW'(1);
      end
    end

    if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  w_nxt = WW'(sat_dim(cfg_wdata, MAX_WIDTH));
        CFG_FRAME_HEIGHT: h_nxt = HW'(sat_dim(cfg_wdata, MAX_HEIGHT));
        default: ;
      endcase
    end

    if (restart) begin
      lcol_nxt = '0;
      lrow_nxt = '0;
      full_nxt = 1'b0;
      dcol_nxt = '0;
      drow_nxt = '0;
      wa_nxt   = '0;
      da_nxt   = '0;
      ws_nxt   = '0;
    end

    // share of pixel (next decision - W + 1), read in the cycle before that decision
    s_off   = (SAW+1)'(DS + 1) - (SAW+1)'(w_r);
    s_sum   = {1'b0, ws_nxt} + s_off;
    s_raddr = (s_sum >= (SAW+1)'(DS)) ? SAW'(s_sum - (SAW+1)'(DS)) : SAW'(s_sum);
  end

  // decision datapath
  always_comb begin
    base         = afwd_r ? afwd_d_r : a_rdata;
    rd_s         = sfwd_r ? sfwd_d_r : share_t'(s_rdata);
    nbr.up_left  = (drow_r != '0) && (dcol_r != '0);
    nbr.up       = (drow_r != '0);
    nbr.up_right = (drow_r != '0) && !d_last_col;
    nbr.left2    = (32'(dcol_r) >= 32'd2);
    nbr.left1    = (dcol_r != '0);
  end

  atk_decide u_decide (
    .base        (base),
    .sh_up_left  (up0_r),
    .sh_up       (up1_r),
    .sh_up_right (rd_s),
    .sh_left2    (sh2_r),
    .sh_left1    (sh1_r),
    .nbr         (nbr),
    .dark        (dark),
    .share       (share)
  );

  // the pixel two rows on takes its first share as it is stored
  assign a_wdata = (dec && prime) ? clamp_add(in_pixel_in, share) : in_pixel_in;

  atk_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DA)
  ) u_win_ram (
    .clk   (clk),
    .we    (load),
    .waddr (wa_r),
    .wdata (a_wdata),
    .raddr (da_nxt),
    .rdata (a_rdata)
  );

  atk_ram #(
    .WIDTH (SHARE_W),
    .DEPTH (DS)
  ) u_share_ram (
    .clk   (clk),
    .we    (dec),
    .waddr (ws_r),
    .wdata (share),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  // output register and skid entry
  always_comb begin
    res.dark = dark;
    res.col  = COORD_W'(dcol_r);
    res.row  = COORD_W'(drow_r);
    res.last = d_last_col && d_last_row;

    out_fire   = ov_r && out_ready;
    ov_nxt     = ov_r;
    skid_v_nxt = skid_v_r;
    take_out   = 1'b0;
    take_skid  = 1'b0;
    move_skid  = 1'b0;
    if (skid_v_r) begin
      if (out_fire) begin
        move_skid  = 1'b1;
        skid_v_nxt = 1'b0;
      end
    end else if (dec) begin
      if (!ov_r || out_fire) begin
        take_out = 1'b1;
        ov_nxt   = 1'b1;
      end else begin
        take_skid  = 1'b1;
        skid_v_nxt = 1'b1;
      end
    end else if (out_fire) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r      <= WW'(sat_dim(CFG_W'(RESET_WIDTH), MAX_WIDTH));
      h_r      <= HW'(sat_dim(CFG_W'(RESET_HEIGHT), MAX_HEIGHT));
      lcol_r   <= '0;
      lrow_r   <= '0;
      full_r   <= 1'b0;
      dcol_r   <= '0;
      drow_r   <= '0;
      wa_r     <= '0;
      da_r     <= '0;
      ws_r     <= '0;
      afwd_r   <= 1'b0;
      sfwd_r   <= 1'b0;
      ov_r     <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      w_r      <= w_nxt;
      h_r      <= h_nxt;
      lcol_r   <= lcol_nxt;
      lrow_r   <= lrow_nxt;
      full_r   <= full_nxt;
      dcol_r   <= dcol_nxt;
      drow_r   <= drow_nxt;
      wa_r     <= wa_nxt;
      da_r     <= da_nxt;
      ws_r     <= ws_nxt;
      afwd_r   <= load && (wa_r == da_nxt);
      sfwd_r   <= dec && (ws_r == s_raddr);
      ov_r     <= ov_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    afwd_d_r <= a_wdata;
    sfwd_d_r <= share;
    if (dec) begin
      up0_r <= up1_r;
      // one-column frames: the row above is the pixel just decided
      up1_r <= (w_r == WW'(1)) ? share : rd_s;
      sh2_r <= sh1_r;
      sh1_r <= share;
    end
    if (take_out) begin
      out_q_r <= res;
    end else if (move_skid) begin
      out_q_r <= skid_q_r;
    end
    if (take_skid) begin
      skid_q_r <= res;
    end
  end

  assign out_valid      = ov_r;
  assign out_pixel_dark = out_q_r.dark;
  assign out_col        = out_q_r.col;
  assign out_row        = out_q_r.row;
  assign out_frame_last = out_q_r.last;

endmodule
